// ===== hdl/tce_pkg.sv =====
// Shared types and constants for the text console engine.
package tce_pkg;

	// Command codes carried on the mode field.
	localparam logic [2:0] MODE_PUT   = 3'd0;
	localparam logic [2:0] MODE_BACK  = 3'd1;
	localparam logic [2:0] MODE_CLEAR = 3'd2;
	localparam logic [2:0] MODE_SET   = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	// Character and attribute constants.
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] RESET_COLOR  = 8'h0F;

	// A 5-bit row times up to 128 columns plus a 7-bit column fits in 12 bits.
	localparam int IDX_W = 12;

	// Sequencer states.
	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_CLEAR  = 6'b000100,
		S_SCROLL = 6'b001000,
		S_BLANK  = 6'b010000,
		S_SPARE  = 6'b100000
	} state_t;

endpackage

// ===== hdl/text_console_engine_top.sv =====
// Text console engine: cell store memory, cursor and command sequencer.
//
// Commands enter on start/mode/char_code/col/row and are taken when start is
// high and busy is low. Each command gives one result beat: done is high for
// one cycle with the cursor, its linear position and, for a read, the cell.
// The receiver cannot stall; results are simply presented for one cycle.
// Put character, newline, backspace, set cursor and read cell need no sweep:
// the result appears in the cycle after acceptance and busy stays low, so a
// new command can follow at once, unless a newline or wrap scrolls. Read data
// comes from the store's registered read port and is shown with the result.
// A scroll (newline or wrap on the last row) walks the store: each row is
// copied up one row, then the bottom row is blanked, then the result follows.
// Clear writes every cell once with a blank, then gives the result.
// After reset a clearing pass fills the store with blanks of attribute 0x0F
// while busy is high; text_color writes are taken at any time. The text_color
// register is written when text_color_we is high.
module text_console_engine_top
	import tce_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_color_we,
	input  logic [7:0]  text_color,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [7:0]  char_code,
	input  logic [6:0]  col,
	input  logic [4:0]  row,
	output logic        done,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_pos,
	output logic [15:0] cell_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam logic [CW-1:0] CNT_LAST  = CW'(CELLS - 1);
	localparam logic [CW-1:0] CNT_COLS  = CW'(COLUMNS);
	localparam logic [CW-1:0] CNT_BOT   = CW'(CELLS - COLUMNS);
	localparam logic [6:0]    COL_LAST  = 7'(COLUMNS - 1);
	localparam logic [4:0]    ROW_LAST  = 5'(ROWS - 1);

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [6:0]      cur_col_q;
	logic [4:0]      cur_row_q;
	logic [7:0]      text_color_q;
	logic            done_q;
	logic            rd_q;
	logic            copy_s1;
	logic [AW-1:0]   wr_addr_s1;
	logic [15:0]     rdata_q;
	logic [15:0]     mem [CELLS];

	logic            accept;
	logic [6:0]      col_cl;
	logic [4:0]      row_cl;
	logic [IDX_W-1:0] cur_idx;
	logic [IDX_W-1:0] back_idx;
	logic [IDX_W-1:0] req_idx;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [15:0]     wdata;
	logic [AW-1:0]   rd_addr;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Clamp the requested coordinates to the screen.
	assign col_cl = (col > COL_LAST) ? COL_LAST : col;
	assign row_cl = (row > ROW_LAST) ? ROW_LAST : row;

	// Linear cell indexes of the cursor, the cell left of it and the request.
	assign cur_idx  = IDX_W'(cur_row_q) * IDX_W'(COLUMNS) + IDX_W'(cur_col_q);
	assign back_idx = cur_idx - IDX_W'(1);
	assign req_idx  = IDX_W'(row_cl) * IDX_W'(COLUMNS) + IDX_W'(col_cl);

	// Result ports follow the cursor registers.
	assign done       = done_q;
	assign cursor_col = cur_col_q;
	assign cursor_row = cur_row_q;
	assign cursor_pos = cur_idx[10:0];
	assign cell_data  = rd_q ? rdata_q : 16'h0000;

	// Store port selection: a pending scroll copy has the write port first.
	always_comb begin
		we      = 1'b0;
		waddr   = cnt_q[AW-1:0];
		wdata   = {text_color_q, BLANK_CHAR};
		rd_addr = cnt_q[AW-1:0];
		priority if (copy_s1) begin
			we    = 1'b1;
			waddr = wr_addr_s1;
			wdata = rdata_q;
		end else begin
			unique case (state_q)
				S_INIT: begin
					we    = 1'b1;
					wdata = {RESET_COLOR, BLANK_CHAR};
				end
				S_CLEAR: begin
					we = 1'b1;
				end
				S_BLANK: begin
					we = 1'b1;
				end
				S_IDLE: begin
					rd_addr = req_idx[AW-1:0];
					if (accept && mode == MODE_PUT && char_code != NEWLINE_CHAR) begin
						we    = 1'b1;
						waddr = cur_idx[AW-1:0];
						wdata = {text_color_q, char_code};
					end else if (accept && mode == MODE_BACK && cur_col_q != 7'd0) begin
						we    = 1'b1;
						waddr = back_idx[AW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Cell store with a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	// Destination of the copy whose source was read this cycle.
	always_ff @(posedge clk) begin
		wr_addr_s1 <= AW'(cnt_q - CNT_COLS);
	end

	// Command sequencer and cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= '0;
			cur_col_q    <= 7'd0;
			cur_row_q    <= 5'd0;
			text_color_q <= RESET_COLOR;
			done_q       <= 1'b0;
			rd_q         <= 1'b0;
			copy_s1      <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			rd_q    <= 1'b0;
			copy_s1 <= 1'b0;
			if (text_color_we) begin
				text_color_q <= text_color;
			end
			unique case (state_q)
				S_INIT: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= S_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						done_q <= 1'b1;
						unique case (mode)
							MODE_PUT: begin
								if (char_code != NEWLINE_CHAR && cur_col_q != COL_LAST) begin
									cur_col_q <= cur_col_q + 7'd1;
								end else begin
									// Newline or wrap: next line, scrolling on the last row.
									cur_col_q <= 7'd0;
									if (cur_row_q == ROW_LAST) begin
										state_q <= S_SCROLL;
										cnt_q   <= CNT_COLS;
										done_q  <= 1'b0;
									end else begin
										cur_row_q <= cur_row_q + 5'd1;
									end
								end
							end
							MODE_BACK: begin
								if (cur_col_q != 7'd0) begin
									cur_col_q <= cur_col_q - 7'd1;
								end
							end
							MODE_CLEAR: begin
								cur_col_q <= 7'd0;
								cur_row_q <= 5'd0;
								state_q   <= S_CLEAR;
								cnt_q     <= '0;
								done_q    <= 1'b0;
							end
							MODE_SET: begin
								cur_col_q <= col_cl;
								cur_row_q <= row_cl;
							end
							MODE_READ: begin
								rd_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				S_CLEAR: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_SCROLL: begin
					copy_s1 <= 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_BLANK;
						cnt_q   <= CNT_BOT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_BLANK: begin
					// Hold the blanking sweep while the last copy drains.
					if (!copy_s1) begin
						if (cnt_q == CNT_LAST) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result beat is never shown while a sweep is still running.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result beat while busy");

	// Clear homes the cursor at once and starts the sweep.
	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_CLEAR) |=>
		(state_q == S_CLEAR && cursor_col == 7'd0 && cursor_row == 5'd0))
		else $error("clear did not home the cursor");

	// The cursor stays on the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q <= COL_LAST) && (cur_row_q <= ROW_LAST))
		else $error("cursor off screen");

	// A copy write only follows a scroll read.
	a_copy_src: assert property (@(posedge clk) disable iff (!arst_n)
		copy_s1 |-> $past(state_q == S_SCROLL))
		else $error("copy write without a scroll read");

endmodule

// ===== dv/text_console_engine_top_test.sv =====
// Self-checking testbench for the text console engine: command stimulus and result scoreboard.
`timescale 1ns / 100ps

module text_console_engine_top_test;
	import tce_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int ITEM_TARGET = 1650;
	localparam int PHASES = 6;
	// A scroll is the longest command: copy, blank, then the result beat.
	localparam int WALK_CYCLES = CELLS + COLUMNS + 1;
	// Every command could be a full walk behind a maximal sender gap, taken four times.
	localparam int LIMIT_CYCLES = CELLS + 4 * (ITEM_TARGET + 400) * (WALK_CYCLES + 16);
	localparam int REPORT_CAP = 100;

	// Shadow console: cell store, cursor and attribute, plus the expected result beats.
	class console_scoreboard #(int NCOL = 80, int NROW = 25);
		typedef struct packed {
			logic [6:0]  col;
			logic [4:0]  row;
			logic [10:0] pos;
			logic [15:0] data;
		} beat_t;

		logic [15:0] cells [NCOL * NROW];
		int unsigned cur_col;
		int unsigned cur_row;
		logic [7:0]  color;
		beat_t       expected_beats [$];
		int          mismatches;
		int          checked;
		int          scrolls;
		int          clears;
		int          reads;
		int          wraps;
		int          dead_backspaces;

		function new();
			int i;
			for (i = 0; i < NCOL * NROW; i++)
				cells[i] = {RESET_COLOR, BLANK_CHAR};
			cur_col = 0;
			cur_row = 0;
			color = RESET_COLOR;
			mismatches = 0;
			checked = 0;
			scrolls = 0;
			clears = 0;
			reads = 0;
			wraps = 0;
			dead_backspaces = 0;
		endfunction

		function void set_color(logic [7:0] value);
			color = value;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// Shift every row up by one and blank the bottom row in the current attribute.
		function void scroll_up();
			int i;
			for (i = 0; i + NCOL < NCOL * NROW; i++)
				cells[i] = cells[i + NCOL];
			for (i = 0; i < NCOL; i++)
				cells[(NROW - 1) * NCOL + i] = {color, BLANK_CHAR};
			cur_row = NROW - 1;
			scrolls++;
		endfunction

		function void line_feed();
			cur_col = 0;
			cur_row++;
			if (cur_row >= NROW) begin
				scroll_up();
			end
		endfunction

		// Apply one accepted command to the shadow and queue the beat it must produce.
		function void note_command(logic [2:0] m, logic [7:0] ch, logic [6:0] c, logic [4:0] r);
			int unsigned cc;
			int unsigned rr;
			int i;
			beat_t b;
			cc = (c > NCOL - 1) ? NCOL - 1 : c;
			rr = (r > NROW - 1) ? NROW - 1 : r;
			b.data = '0;
			case (m)
				MODE_PUT: begin
					if (ch == NEWLINE_CHAR) begin
						line_feed();
					end else begin
						cells[cur_row * NCOL + cur_col] = {color, ch};
						cur_col++;
						if (cur_col >= NCOL) begin
							wraps++;
							line_feed();
						end
					end
				end
				MODE_BACK: begin
					if (cur_col != 0) begin
						cur_col--;
						cells[cur_row * NCOL + cur_col] = {color, BLANK_CHAR};
					end else begin
						dead_backspaces++;
					end
				end
				MODE_CLEAR: begin
					for (i = 0; i < NCOL * NROW; i++)
						cells[i] = {color, BLANK_CHAR};
					cur_col = 0;
					cur_row = 0;
					clears++;
				end
				MODE_SET: begin
					cur_col = cc;
					cur_row = rr;
				end
				MODE_READ: begin
					b.data = cells[rr * NCOL + cc];
					reads++;
				end
				default: begin
				end
			endcase
			b.col = 7'(cur_col);
			b.row = 5'(cur_row);
			b.pos = 11'(cur_row * NCOL + cur_col);
			expected_beats.push_back(b);
		endfunction

		task report_mismatch(string what, int unsigned got, int unsigned want);
			mismatches++;
			// Keep the log readable when everything goes wrong at once.
			if (mismatches <= REPORT_CAP) begin
				$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
			end
		endtask

		// Compare one result beat with the oldest expectation.
		task check_result(logic [6:0] c, logic [4:0] r, logic [10:0] p, logic [15:0] d);
			beat_t want;
			if (expected_beats.size() == 0) begin
				report_mismatch("result beat with nothing expected", 1, 0);
			end else begin
				want = expected_beats.pop_front();
				checked++;
				if (c !== want.col)
					report_mismatch("cursor_col", c, want.col);
				if (r !== want.row)
					report_mismatch("cursor_row", r, want.row);
				if (p !== want.pos)
					report_mismatch("cursor_pos", p, want.pos);
				if (d !== want.data)
					report_mismatch("cell_data", d, want.data);
			end
		endtask

		task check_leftovers();
			if (expected_beats.size() != 0) begin
				report_mismatch("result beats never delivered", expected_beats.size(), 0);
			end
		endtask
	endclass

	typedef console_scoreboard #(COLUMNS, ROWS) board_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_color_we = 1'b0;
	logic [7:0]  text_color = RESET_COLOR;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  mode = MODE_PUT;
	logic [7:0]  char_code = '0;
	logic [6:0]  col = '0;
	logic [4:0]  row = '0;
	logic        done;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [10:0] cursor_pos;
	logic [15:0] cell_data;

	board_t sb;
	int     items_sent = 0;
	int     gap_pct = 0;
	int     cycle_count = 0;

	text_console_engine_top #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text_color_we(text_color_we),
		.text_color(text_color),
		.start(start),
		.busy(busy),
		.mode(mode),
		.char_code(char_code),
		.col(col),
		.row(row),
		.done(done),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.cursor_pos(cursor_pos),
		.cell_data(cell_data)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result beats are taken at the edge that ends their cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(cursor_col, cursor_row, cursor_pos, cell_data);
		end
	end

	// Watchdog on a hung handshake.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles.", cycle_count);
		$display("FAILED: results differ");
		$finish;
	end

	// Present one command and hold it until the engine takes it.
	task automatic issue_command(input logic [2:0] m, input logic [7:0] ch,
			input logic [6:0] c, input logic [4:0] r);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		mode <= m;
		char_code <= ch;
		col <= c;
		row <= r;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(m, ch, c, r);
		items_sent++;
	endtask

	// Stop sending and wait for every outstanding result beat.
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_color(input logic [7:0] value);
		text_color <= value;
		text_color_we <= 1'b1;
		@(posedge clk);
		text_color_we <= 1'b0;
		sb.set_color(value);
	endtask

	// Directed corner cases under the reset attribute.
	task automatic run_directed();
		int k;
		issue_command(MODE_READ, 8'($urandom), 7'd0, 5'd0);
		issue_command(MODE_READ, 8'($urandom), 7'h7F, 5'h1F);
		issue_command(MODE_PUT, 8'h41, 7'($urandom), 5'($urandom));
		issue_command(MODE_PUT, 8'hFF, 7'($urandom), 5'($urandom));
		issue_command(MODE_PUT, 8'h00, 7'($urandom), 5'($urandom));
		issue_command(MODE_PUT, 8'h80, 7'($urandom), 5'($urandom));
		issue_command(MODE_READ, 8'($urandom), 7'd1, 5'd0);
		issue_command(MODE_BACK, 8'($urandom), 7'($urandom), 5'($urandom));
		issue_command(MODE_READ, 8'($urandom), 7'd3, 5'd0);
		issue_command(MODE_PUT, NEWLINE_CHAR, 7'($urandom), 5'($urandom));
		// Backspace at the left edge does nothing.
		issue_command(MODE_BACK, 8'($urandom), 7'($urandom), 5'($urandom));
		// Just past the last column and row: clamped to the bottom-right cell.
		issue_command(MODE_SET, 8'($urandom), 7'(COLUMNS), 5'(ROWS));
		// Writing the bottom-right cell wraps and scrolls.
		issue_command(MODE_PUT, 8'h5A, 7'($urandom), 5'($urandom));
		issue_command(MODE_READ, 8'($urandom), 7'(COLUMNS - 1), 5'(ROWS - 2));
		issue_command(MODE_READ, 8'($urandom), 7'd0, 5'd0);
		// Newline on the bottom row scrolls.
		issue_command(MODE_SET, 8'($urandom), 7'd0, 5'(ROWS - 1));
		issue_command(MODE_PUT, NEWLINE_CHAR, 7'($urandom), 5'($urandom));
		// Wrap from the last column of the top row, no scroll.
		issue_command(MODE_SET, 8'($urandom), 7'(COLUMNS - 1), 5'd0);
		issue_command(MODE_PUT, 8'h57, 7'($urandom), 5'($urandom));
		// Unused mode codes leave everything alone.
		for (k = int'(MODE_READ) + 1; k < 8; k++)
			issue_command(3'(k), 8'($urandom), 7'($urandom), 5'($urandom));
		issue_command(MODE_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
		issue_command(MODE_READ, 8'($urandom), 7'(COLUMNS - 1), 5'(ROWS - 1));
	endtask

	// One random sequence; most are typed text runs and read-backs of what was typed.
	task automatic run_sequence();
		int kind;
		int n;
		int k;
		int pick;
		logic [4:0] r;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			// Place the cursor anywhere, then type text with newlines and corrections.
			issue_command(MODE_SET, 8'($urandom), 7'($urandom), 5'($urandom));
			n = $urandom_range(3, 40);
			for (k = 0; k < n; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 9)
					issue_command(MODE_PUT, NEWLINE_CHAR, 7'($urandom), 5'($urandom));
				else if (pick < 17)
					issue_command(MODE_BACK, 8'($urandom), 7'($urandom), 5'($urandom));
				else
					issue_command(MODE_PUT, 8'($urandom), 7'($urandom), 5'($urandom));
			end
		end else if (kind < 78) begin
			// Read back cells just behind the cursor, and some anywhere.
			n = $urandom_range(2, 12);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 2) != 0) begin
					r = 5'(sb.cur_row);
					if (r != 0 && $urandom_range(0, 3) == 0)
						r = r - 5'd1;
					issue_command(MODE_READ, 8'($urandom),
						7'($urandom_range(0, sb.cur_col)), r);
				end else begin
					issue_command(MODE_READ, 8'($urandom), 7'($urandom), 5'($urandom));
				end
			end
		end else if (kind < 90) begin
			// Erase near the left edge, past column zero, then look at the line.
			issue_command(MODE_SET, 8'($urandom), 7'($urandom_range(0, 6)), 5'($urandom));
			n = $urandom_range(1, 10);
			for (k = 0; k < n; k++)
				issue_command(MODE_BACK, 8'($urandom), 7'($urandom), 5'($urandom));
			for (k = 0; k < 3; k++)
				issue_command(MODE_READ, 8'($urandom), 7'($urandom_range(0, 8)),
					5'(sb.cur_row));
		end else if (kind < 97) begin
			// Noise: any mode code with any fields.
			n = $urandom_range(1, 4);
			for (k = 0; k < n; k++)
				issue_command(3'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
		end else begin
			issue_command(MODE_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
			n = $urandom_range(1, 5);
			for (k = 0; k < n; k++)
				issue_command(MODE_PUT, 8'($urandom), 7'($urandom), 5'($urandom));
			issue_command(MODE_READ, 8'($urandom), 7'($urandom), 5'($urandom));
		end
	endtask

	// Reset, directed part, then random phases under different attributes.
	initial begin
		int phase;
		int phase_end;
		logic [7:0] value;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		gap_pct = 25;
		run_directed();
		for (phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			if (phase == 0)
				value = 8'h00;
			else if (phase == 1)
				value = 8'hFF;
			else
				value = 8'($urandom);
			write_color(value);
			// Phase two and the closing phase run without sender gaps.
			gap_pct = (phase == 2 || phase == PHASES - 1) ? 0 : 25;
			phase_end = items_sent + ITEM_TARGET / PHASES;
			while (items_sent < phase_end)
				run_sequence();
		end
		wait_drained();
		repeat (WALK_CYCLES + 8) @(posedge clk);
		sb.check_leftovers();
		$display("Sent %0d commands, checked %0d result beats under %0d attribute settings.",
			items_sent, sb.checked, PHASES + 1);
		$display("Saw %0d scrolls, %0d clears, %0d wraps, %0d cell reads, %0d edge backspaces.",
			sb.scrolls, sb.clears, sb.wraps, sb.reads, sb.dead_backspaces);
		if (sb.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches.", sb.mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
